// File: design/modexp_pkg.sv
`default_nettype none
package modexp_pkg;
    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_ENC_EXP = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEC_EXP = 2'd2;
    typedef logic [WIDTH-1:0] t_word;
endpackage
`default_nettype wire

// File: design/modexp_mulmod.sv
`default_nettype none
module modexp_mulmod (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire modexp_pkg::t_word i_a,
    input  wire modexp_pkg::t_word i_b,
    input  wire modexp_pkg::t_word i_m,
    output logic                   o_done,
    output modexp_pkg::t_word      o_p
);
    logic                            r_busy, n_busy;
    logic [modexp_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    modexp_pkg::t_word               r_acc, n_acc, r_a, r_b, n_b;
    logic                            r_done;
    logic [modexp_pkg::WIDTH:0]      w_dbl, w_sum;
    modexp_pkg::t_word               w_red;

    always_comb begin
        w_dbl = {r_acc, 1'b0};
        if (w_dbl >= {1'b0, i_m}) w_dbl = w_dbl - {1'b0, i_m};
        w_red = w_dbl[modexp_pkg::WIDTH-1:0];
        w_sum = {1'b0, w_red} + {1'b0, r_a};
        if (r_b[modexp_pkg::WIDTH-1]) begin
            if (w_sum >= {1'b0, i_m}) w_sum = w_sum - {1'b0, i_m};
            w_red = w_sum[modexp_pkg::WIDTH-1:0];
        end
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = w_red;
            n_b   = {r_b[modexp_pkg::WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && !n_busy && !i_start;
        end
        r_acc <= n_acc;
        r_b   <= n_b;
        if (i_start) r_a <= i_a;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
`default_nettype wire

// File: design/modular_exponentiation.sv
`default_nettype none
// Modular exponentiation, right-to-left square and multiply.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data;
// index 0 modulus, 1 encrypt exponent, 2 decrypt exponent; other indexes
// are dropped. Write only while idle. Reset loads modulus 2, exponents 1.
// Input beat: i_op selects the exponent, i_message is the base.
// The base is first reduced by a bit-serial modulo pass (S_RED).
// Each exponent bit then runs a multiply (if set) and a square, each a
// shift-and-add modular multiply started in S_MUL and awaited in S_WAIT;
// a clear bit skips the multiply. A modulus below two skips the reduction
// and the loop and goes straight from S_IDLE to S_OUT.
// One item in flight at a time; input ready returns the cycle after the
// result is loaded, so a new item is taken only once the last is done.
// The result beat waits in an output register while o_valid is high and
// i_ready low; the next input beat is taken while it waits.
// Modulus below two yields zero.
module modular_exponentiation (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [modexp_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire modexp_pkg::t_word       i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_op,
    input  wire modexp_pkg::t_word       i_message,
    output logic                         o_valid,
    input  wire                          i_ready,
    output modexp_pkg::t_word            o_result
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                   r_state, n_state;
    modexp_pkg::t_word            r_mod, r_enc, r_dec;
    modexp_pkg::t_word            r_exp, r_base, r_acc, r_msg, r_rem;
    logic [modexp_pkg::CNT_W-1:0] r_cnt;
    logic                         r_sqr_ph;
    logic                         r_ovalid;
    modexp_pkg::t_word            r_res;
    logic                         w_start, w_done;
    modexp_pkg::t_word            w_a, w_b, w_p;
    logic [modexp_pkg::WIDTH:0]   w_sh;
    logic                         w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign o_valid     = r_ovalid;
    assign o_result    = r_res;

    assign w_sh = {r_rem, r_msg[modexp_pkg::WIDTH-1]};

    always_comb begin
        w_start = 1'b0;
        w_a = r_acc;
        w_b = r_base;
        if (r_sqr_ph) w_a = r_base;
        if (r_state == S_MUL && !r_sqr_ph && r_exp[0]) w_start = 1'b1;
        if (r_state == S_MUL && r_sqr_ph) w_start = 1'b1;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = (r_mod < 2) ? S_OUT : S_RED;
            S_RED:  if (r_cnt == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1)) n_state = S_MUL;
            S_MUL:  if (w_start) n_state = S_WAIT;
            S_WAIT: if (w_done) begin
                if (r_sqr_ph && r_cnt == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1))
                    n_state = S_OUT;
                else
                    n_state = S_MUL;
            end
            S_OUT:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mod    <= modexp_pkg::t_word'(2);
            r_enc    <= modexp_pkg::t_word'(1);
            r_dec    <= modexp_pkg::t_word'(1);
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_sqr_ph <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    modexp_pkg::REG_MODULUS: r_mod <= i_cfg_data;
                    modexp_pkg::REG_ENC_EXP: r_enc <= i_cfg_data;
                    modexp_pkg::REG_DEC_EXP: r_dec <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_in_acc) begin
                    r_cnt    <= '0;
                    r_sqr_ph <= 1'b0;
                    r_msg    <= i_message;
                    r_rem    <= '0;
                    r_acc    <= (r_mod < 2) ? '0 : modexp_pkg::t_word'(1);
                    r_exp    <= i_op ? r_dec : r_enc;
                end
                S_RED: begin
                    r_msg <= {r_msg[modexp_pkg::WIDTH-2:0], 1'b0};
                    if (w_sh >= {1'b0, r_mod})
                        r_rem <= modexp_pkg::t_word'(w_sh - {1'b0, r_mod});
                    else
                        r_rem <= w_sh[modexp_pkg::WIDTH-1:0];
                    if (r_cnt == modexp_pkg::CNT_W'(modexp_pkg::WIDTH - 1)) begin
                        r_cnt <= '0;
                        r_base <= (w_sh >= {1'b0, r_mod})
                            ? modexp_pkg::t_word'(w_sh - {1'b0, r_mod})
                            : w_sh[modexp_pkg::WIDTH-1:0];
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: if (!w_start) r_sqr_ph <= 1'b1;
                S_WAIT: if (w_done) begin
                    if (!r_sqr_ph) begin
                        r_acc    <= w_p;
                        r_sqr_ph <= 1'b1;
                    end else begin
                        r_base   <= w_p;
                        r_sqr_ph <= 1'b0;
                        r_exp    <= {1'b0, r_exp[modexp_pkg::WIDTH-1:1]};
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                S_OUT: if (!r_ovalid || i_ready) begin
                    r_ovalid <= 1'b1;
                    r_res    <= r_acc;
                end
                default: ;
            endcase
        end
    end

    modexp_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (r_mod),
        .o_done  (w_done),
        .o_p     (w_p)
    );

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_res))
        else $error("result dropped while stalled");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_WAIT)
        else $error("multiplier done outside wait");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> r_state == S_WAIT)
        else $error("start not followed by wait");
`endif
endmodule
`default_nettype wire

// File: dv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
module modular_exponentiation_tb;

    localparam logic [modexp_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY = 2400;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY;
    localparam int N_RANDOM = 270;

    typedef struct {
        logic              op;
        modexp_pkg::t_word message;
        logic              known;
        modexp_pkg::t_word result;
    } t_vector;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [modexp_pkg::IDX_W-1:0]  i_cfg_index;
    modexp_pkg::t_word             i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_op;
    modexp_pkg::t_word             i_message;
    logic                          o_valid;
    logic                          i_ready;
    modexp_pkg::t_word             o_result;

    modexp_pkg::t_word mdl_modulus;
    modexp_pkg::t_word mdl_enc_exp;
    modexp_pkg::t_word mdl_dec_exp;
    modexp_pkg::t_word pending_results[$];
    int                errors;
    int                idle_cycles;
    int                received;
    bit                calm;
    t_vector           vectors[$];

    modular_exponentiation dut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic modexp_pkg::t_word mulmod(modexp_pkg::t_word a, modexp_pkg::t_word b,
                                                 modexp_pkg::t_word m);
        logic [2*modexp_pkg::WIDTH-1:0] p;
        p = {{modexp_pkg::WIDTH{1'b0}}, a} * {{modexp_pkg::WIDTH{1'b0}}, b};
        return modexp_pkg::t_word'(p % {{modexp_pkg::WIDTH{1'b0}}, m});
    endfunction

    function automatic modexp_pkg::t_word powmod(modexp_pkg::t_word base,
                                                 modexp_pkg::t_word expo,
                                                 modexp_pkg::t_word m);
        modexp_pkg::t_word acc;
        modexp_pkg::t_word b;
        if (m < 2)
            return '0;
        acc = 1;
        b = base % m;
        for (int i = 0; i < modexp_pkg::WIDTH; i++) begin
            if (expo[i])
                acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_ready && o_valid) begin
                received <= received + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, o_result);
                    errors <= errors + 1;
                end else begin
                    if (o_result !== pending_results[0]) begin
                        $display("%0t: result expected %h actual %h",
                                 $time, pending_results[0], o_result);
                        errors <= errors + 1;
                    end
                    void'(pending_results.pop_front());
                end
            end
            if ((i_valid && o_ready) || (i_ready && o_valid) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [modexp_pkg::IDX_W-1:0] idx,
                             input modexp_pkg::t_word data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            modexp_pkg::REG_MODULUS: mdl_modulus = data;
            modexp_pkg::REG_ENC_EXP: mdl_enc_exp = data;
            modexp_pkg::REG_DEC_EXP: mdl_dec_exp = data;
            default: ;
        endcase
    endtask

    task automatic send_item(input logic op, input modexp_pkg::t_word msg, input logic known,
                             input modexp_pkg::t_word result);
        while (!calm && $urandom_range(99) < 15)
            @(posedge i_clk);
        i_valid   <= 1'b1;
        i_op      <= op;
        i_message <= msg;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_results.push_back(known ? result
                                  : powmod(msg, op ? mdl_dec_exp : mdl_enc_exp, mdl_modulus));
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic random_key;
        modexp_pkg::t_word m;
        case ($urandom_range(3))
            0: m = $urandom_range(255, 2);
            1: m = $urandom_range(65535, 2);
            2: m = 32'hFFFF_FFFF - $urandom_range(1000);
            default: m = $urandom;
        endcase
        write_reg(modexp_pkg::REG_MODULUS, m);
        write_reg(modexp_pkg::REG_ENC_EXP, $urandom);
        write_reg(modexp_pkg::REG_DEC_EXP,
                  ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom);
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        received = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_message = '0;
        i_ready = 1'b0;
        mdl_modulus = 2;
        mdl_enc_exp = 1;
        mdl_dec_exp = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: x^1 mod 2
        vectors.push_back('{1'b0, 32'd7, 1'b1, 32'd1});
        vectors.push_back('{1'b1, 32'hFFFF_FFFE, 1'b1, 32'd0});
        foreach (vectors[i])
            send_item(vectors[i].op, vectors[i].message, vectors[i].known, vectors[i].result);
        drain();

        write_reg(modexp_pkg::REG_MODULUS, 32'hFFFF_FFFF);
        write_reg(modexp_pkg::REG_ENC_EXP, 32'd0);
        write_reg(modexp_pkg::REG_DEC_EXP, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'd5);
        vectors = {};
        vectors.push_back('{1'b0, 32'h0, 1'b1, 32'd1});
        vectors.push_back('{1'b0, 32'hFFFF_FFFF, 1'b1, 32'd1});
        vectors.push_back('{1'b1, 32'h0, 1'b1, 32'd0});
        vectors.push_back('{1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0});
        vectors.push_back('{1'b1, 32'd1, 1'b1, 32'd1});
        vectors.push_back('{1'b1, 32'hFFFF_FFFE, 1'b0, 32'd0});
        vectors.push_back('{1'b1, 32'h8000_0000, 1'b0, 32'd0});
        vectors.push_back('{1'b1, 32'h5555_5555, 1'b0, 32'd0});
        foreach (vectors[i])
            send_item(vectors[i].op, vectors[i].message, vectors[i].known, vectors[i].result);
        drain();

        write_reg(modexp_pkg::REG_MODULUS, 32'd3233);
        write_reg(modexp_pkg::REG_ENC_EXP, 32'd17);
        write_reg(modexp_pkg::REG_DEC_EXP, 32'd2753);
        vectors = {};
        vectors.push_back('{1'b0, 32'd65, 1'b1, 32'd2790});
        vectors.push_back('{1'b1, 32'd2790, 1'b1, 32'd65});
        vectors.push_back('{1'b0, 32'd3233, 1'b1, 32'd0});
        vectors.push_back('{1'b0, 32'hAAAA_AAAA, 1'b0, 32'd0});
        vectors.push_back('{1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0});
        foreach (vectors[i])
            send_item(vectors[i].op, vectors[i].message, vectors[i].known, vectors[i].result);
        drain();

        // modulus below two gives zero
        write_reg(modexp_pkg::REG_MODULUS, 32'd1);
        send_item(1'b0, 32'd9, 1'b1, 32'd0);
        drain();
        write_reg(modexp_pkg::REG_MODULUS, 32'd0);
        send_item(1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 30 == 0) begin
                drain();
                random_key();
            end
            calm = (i >= 90 && i < 130);
            send_item(1'($urandom_range(1)), $urandom, 1'b0, '0);
        end
        calm = 1'b0;
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: modular_exponentiation.f
design/modexp_pkg.sv
design/modexp_mulmod.sv
design/modular_exponentiation.sv
dv/modular_exponentiation_tb.sv
